[sv/upd_pkg.sv]
package upd_pkg;

  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOWER_BASE = 8'h61 - 8'd10;
  localparam logic [7:0] CH_UPPER_BASE = 8'h41 - 8'd10;
  localparam logic [7:0] CH_DIGIT_BASE = 8'h30;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       two;
    logic [7:0] c0;
    logic       e0;
    logic [7:0] c1;
    logic       e1;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - CH_DIGIT_BASE;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - CH_LOWER_BASE;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - CH_UPPER_BASE;
    end
    return v[3:0];
  endfunction

endpackage

[sv/upd_front.sv]
module upd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_char,
  input  logic            full,
  output logic            push,
  output upd_pkg::entry_t entry
);

  upd_pkg::phase_t phase, phase_next;
  logic [7:0] held, held_next;
  logic       accept;
  logic       go_plain;
  logic       pre_v;
  logic       pl_v;
  logic [7:0] pl_c;
  logic       pl_e;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_next = phase;
    held_next  = held;
    go_plain   = 1'b0;
    pre_v      = 1'b0;
    pl_v       = 1'b0;
    pl_c       = in_char;
    pl_e       = 1'b0;
    case (phase)
      upd_pkg::PH_PCT: begin
        if (upd_pkg::is_hex(in_char)) begin
          held_next  = in_char;
          phase_next = upd_pkg::PH_DIG;
        end else begin
          go_plain = 1'b1;
        end
      end
      upd_pkg::PH_DIG: begin
        if (upd_pkg::is_hex(in_char)) begin
          pl_v       = 1'b1;
          pl_c       = {upd_pkg::hex_val(held), upd_pkg::hex_val(in_char)};
          phase_next = upd_pkg::PH_IDLE;
        end else begin
          pre_v    = 1'b1;
          go_plain = 1'b1;
        end
      end
      default: begin
        go_plain = 1'b1;
      end
    endcase
    if (go_plain) begin
      phase_next = upd_pkg::PH_IDLE;
      if (in_char == upd_pkg::CH_NUL) begin
        pl_v = 1'b1;
        pl_c = upd_pkg::CH_NUL;
        pl_e = 1'b1;
      end else if (in_char == upd_pkg::CH_PERCENT) begin
        phase_next = upd_pkg::PH_PCT;
      end else if (in_char == upd_pkg::CH_PLUS) begin
        pl_v = 1'b1;
        pl_c = upd_pkg::CH_SPACE;
      end else begin
        pl_v = 1'b1;
      end
    end
  end

  always_comb begin
    if (pre_v) begin
      entry.two = pl_v;
      entry.c0  = held;
      entry.e0  = 1'b0;
    end else begin
      entry.two = 1'b0;
      entry.c0  = pl_c;
      entry.e0  = pl_e;
    end
    entry.c1 = pl_c;
    entry.e1 = pl_e;
  end

  assign push = accept && (pre_v || pl_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= upd_pkg::PH_IDLE;
      held  <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

`ifndef SYNTHESIS
  a_end_clears_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && pl_e) |=> (phase == upd_pkg::PH_IDLE))
    else $error("escape state survives a terminator");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("word pushed into a full queue");
`endif

endmodule

[sv/upd_fifo.sv]
module upd_fifo #(
  parameter int DEPTH = upd_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  upd_pkg::entry_t wr_entry,
  input  logic            pop,
  output upd_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("word popped from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

[sv/upd_back.sv]
module upd_back (
  input  logic            clk,
  input  logic            rst,
  input  upd_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_char,
  output logic            is_end
);

  logic idx;
  logic take;

  assign out_valid = !empty;
  assign out_char  = idx ? head.c1 : head.c0;
  assign is_end    = idx ? head.e1 : head.e0;
  assign take      = out_valid && !out_stall;
  assign pop       = take && (idx || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 1'b0;
    end else if (take) begin
      idx <= !idx && head.two;
    end
  end

`ifndef SYNTHESIS
  a_idx_has_entry: assert property (@(posedge clk) disable iff (rst)
    idx |-> (!empty && head.two))
    else $error("second word selected without a pair at the head");
`endif

endmodule

[sv/url_percent_decoder_top.sv]
// Streaming URL decoder: one encoded byte is taken per cycle while the queue is not full, and
// decoded words leave one per cycle while out_stall is low, with plus turned into space and
// percent escapes folded into single bytes; a zero byte ends the string and gives a word with
// is_end set. A front stage decodes and holds the escape state, and a small queue (QDEPTH
// entries) feeds a back stage that sends the words out. An input byte gives zero, one or two
// words; only a broken escape gives two, and the queue absorbs the extra word. The front stage
// is combinational and the queue write is registered.
module url_percent_decoder_top #(
  parameter int QDEPTH = upd_pkg::QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       is_end
);

  upd_pkg::entry_t wr_entry;
  upd_pkg::entry_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .full     (full),
    .push     (push),
    .entry    (wr_entry)
  );

  upd_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .is_end    (is_end)
  );

endmodule

[verif/tb.sv]
module tb;

  localparam int TARGET_CHARS = 1850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } decoded_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       is_end;

  decoded_word_t   pending_decoded[$];
  upd_pkg::phase_t esc_phase;
  logic [7:0]      held_digit;
  int              mismatches;
  int              chars_sent;
  bit              tx_idle;
  bit              rx_idle;
  int              long_hold;

  url_percent_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .is_end   (is_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return 8'h30 + 8'(k);
    end else if (k < 16) begin
      return 8'h61 + 8'(k - 10);
    end
    return 8'h41 + 8'(k - 16);
  endfunction

  task automatic push_word(input logic [7:0] c, input logic e);
    decoded_word_t w;
    w.ch = c;
    w.fin = e;
    pending_decoded.push_back(w);
  endtask

  task automatic take_plain(input logic [7:0] c);
    esc_phase = upd_pkg::PH_IDLE;
    if (c == upd_pkg::CH_NUL) begin
      push_word(upd_pkg::CH_NUL, 1'b1);
    end else if (c == upd_pkg::CH_PERCENT) begin
      esc_phase = upd_pkg::PH_PCT;
    end else if (c == upd_pkg::CH_PLUS) begin
      push_word(upd_pkg::CH_SPACE, 1'b0);
    end else begin
      push_word(c, 1'b0);
    end
  endtask

  task automatic decode_char(input logic [7:0] c);
    case (esc_phase)
      upd_pkg::PH_PCT: begin
        if (is_hex_digit(c)) begin
          held_digit = c;
          esc_phase = upd_pkg::PH_DIG;
        end else begin
          take_plain(c);
        end
      end
      upd_pkg::PH_DIG: begin
        if (is_hex_digit(c)) begin
          push_word({digit_value(held_digit), digit_value(c)}, 1'b0);
          esc_phase = upd_pkg::PH_IDLE;
        end else begin
          push_word(held_digit, 1'b0);
          take_plain(c);
        end
      end
      default: begin
        take_plain(c);
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_char = c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_decoded.size() != 0) @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected 0x%02h, got 0x%02h", what, want, got);
    end
  endtask

  task automatic test_plain_and_plus();
    send_char(8'hFF);
    send_char(8'h01);
    send_char(upd_pkg::CH_PLUS);
    send_char(upd_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_good_escapes();
    send_text("%41%fF%00");
    send_char(upd_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_broken_escapes();
    send_text("%z%9%A+%+");
    send_char(upd_pkg::CH_NUL);
    wait_drained();
  endtask

  task automatic test_end_inside_escape();
    send_text("%4");
    send_char(upd_pkg::CH_NUL);
    send_char(upd_pkg::CH_PERCENT);
    send_char(upd_pkg::CH_NUL);
    wait_drained();
  endtask

  // The receiver holds off while bytes keep coming, so the queue fills and the
  // input side has to stall.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    long_hold = 80;
    for (int i = 0; i < 10; i++) begin
      send_text("%4x");
    end
    send_char(upd_pkg::CH_NUL);
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic send_random_string();
    int tokens;
    int kind;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    tokens = $urandom_range(0, 24);
    for (int i = 0; i < tokens; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        send_char(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind == 4) begin
        send_char(upd_pkg::CH_PLUS);
      end else if (kind <= 7) begin
        send_char(upd_pkg::CH_PERCENT);
        send_char(rand_hex_digit());
        send_char(rand_hex_digit());
      end else if (kind == 8) begin
        send_char(upd_pkg::CH_PERCENT);
        if ($urandom_range(0, 1) == 1) begin
          send_char(rand_hex_digit());
        end
        send_char(8'($urandom_range(1, 255)));
      end else begin
        send_char(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      send_char(upd_pkg::CH_PERCENT);
      if ($urandom_range(0, 1) == 1) begin
        send_char(rand_hex_digit());
      end
    end
    send_char(upd_pkg::CH_NUL);
  endtask

  task automatic test_random_strings();
    while (chars_sent < TARGET_CHARS) begin
      send_random_string();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk) begin
    decoded_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decoded.size() == 0) begin
        flag_mismatch("unexpected word", 0, out_char);
      end else begin
        want = pending_decoded.pop_front();
        if (out_char !== want.ch) begin
          flag_mismatch("out_char", want.ch, out_char);
        end
        if (is_end !== want.fin) begin
          flag_mismatch("is_end", want.fin, is_end);
        end
      end
    end
  end

  initial begin : receiver
    int k;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      k = rx_idle ? $urandom_range(0, 7) : 0;
      if (long_hold > 0) begin
        k = long_hold;
        long_hold = 0;
      end
      out_stall = 1'b1;
      repeat (k) @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_char = 8'h00;
    esc_phase = upd_pkg::PH_IDLE;
    held_digit = 8'h00;
    mismatches = 0;
    chars_sent = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    long_hold = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_plain_and_plus();
    test_good_escapes();
    test_broken_escapes();
    test_end_inside_escape();
    test_backpressure();
    test_random_strings();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_decoded.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_fifo.sv
sv/upd_back.sv
sv/url_percent_decoder_top.sv
verif/tb.sv
